>>> hdl/stk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_pkg
// Shared types and constants of the source code tokenizer.
// ----------------------------------------------------------------------------
package stk_pkg;

	localparam int LINE_BITS   = 20;
	localparam int COLUMN_BITS = 16;
	localparam int LENGTH_BITS = 16;

	localparam logic [LINE_BITS-1:0]   LINE_TOP = {LINE_BITS{1'b1}};
	localparam logic [COLUMN_BITS-1:0] COL_TOP  = {COLUMN_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_TOP  = {LENGTH_BITS{1'b1}};

	localparam logic [1:0] KIND_LIT = 2'd0;
	localparam logic [1:0] KIND_TOK = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_BADCHAR = 2'd1;
	localparam logic [1:0] ERR_UNTERM  = 2'd2;
	localparam logic [1:0] ERR_CHRSIZE = 2'd3;

	localparam logic [5:0] T_ADD    = 6'd0;
	localparam logic [5:0] T_SUB    = 6'd1;
	localparam logic [5:0] T_MUL    = 6'd2;
	localparam logic [5:0] T_DIV    = 6'd3;
	localparam logic [5:0] T_MOD    = 6'd4;
	localparam logic [5:0] T_ANDB   = 6'd5;
	localparam logic [5:0] T_ANDL   = 6'd6;
	localparam logic [5:0] T_ORB    = 6'd7;
	localparam logic [5:0] T_ORL    = 6'd8;
	localparam logic [5:0] T_TILDE  = 6'd9;
	localparam logic [5:0] T_XOR    = 6'd10;
	localparam logic [5:0] T_SHL    = 6'd11;
	localparam logic [5:0] T_LE     = 6'd12;
	localparam logic [5:0] T_LT     = 6'd13;
	localparam logic [5:0] T_SHR    = 6'd14;
	localparam logic [5:0] T_GE     = 6'd15;
	localparam logic [5:0] T_GT     = 6'd16;
	localparam logic [5:0] T_NE     = 6'd17;
	localparam logic [5:0] T_NOTB   = 6'd18;
	localparam logic [5:0] T_EQ     = 6'd19;
	localparam logic [5:0] T_ASSIGN = 6'd20;
	localparam logic [5:0] T_LPAR   = 6'd21;
	localparam logic [5:0] T_RPAR   = 6'd22;
	localparam logic [5:0] T_LBRK   = 6'd23;
	localparam logic [5:0] T_RBRK   = 6'd24;
	localparam logic [5:0] T_LBRC   = 6'd25;
	localparam logic [5:0] T_RBRC   = 6'd26;
	localparam logic [5:0] T_DOT    = 6'd27;
	localparam logic [5:0] T_SEMI   = 6'd28;
	localparam logic [5:0] T_COMMA  = 6'd29;
	localparam logic [5:0] T_CHAR   = 6'd30;
	localparam logic [5:0] T_STRING = 6'd31;
	localparam logic [5:0] T_INT    = 6'd32;
	localparam logic [5:0] T_DEC    = 6'd33;
	localparam logic [5:0] T_BOOL   = 6'd34;
	localparam logic [5:0] T_ID     = 6'd35;

	typedef enum logic [16:0] {
		M_IDLE    = 17'h00001,
		M_COMMENT = 17'h00002,
		M_NUM     = 17'h00004,
		M_DEC     = 17'h00008,
		M_IDENT   = 17'h00010,
		M_STR     = 17'h00020,
		M_STR_ESC = 17'h00040,
		M_CHR     = 17'h00080,
		M_CHR_ESC = 17'h00100,
		M_AMP     = 17'h00200,
		M_BAR     = 17'h00400,
		M_LT      = 17'h00800,
		M_GT      = 17'h01000,
		M_BANG    = 17'h02000,
		M_EQ      = 17'h04000,
		M_ERROR   = 17'h08000,
		M_DONE    = 17'h10000
	} stk_mode_t;

	typedef struct packed {
		stk_mode_t              mode;
		logic [LINE_BITS-1:0]   cur_line;
		logic [COLUMN_BITS-1:0] cur_col;
		logic [LINE_BITS-1:0]   st_line;
		logic [COLUMN_BITS-1:0] st_col;
		logic [LENGTH_BITS-1:0] cnt;
		logic [3:0]             bmatch;
		logic [7:0]             held;
		logic [1:0]             held_cnt;
	} stk_state_t;

	typedef struct packed {
		logic [1:0]             kind;
		logic [5:0]             token_type;
		logic [7:0]             literal_byte;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] column;
		logic [LENGTH_BITS-1:0] literal_length;
		logic [1:0]             error_code;
		logic                   last;
	} stk_res_t;

endpackage
`default_nettype wire

>>> hdl/stk_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_step
// Next-state and result logic for one source byte; gives up to two results.
// ----------------------------------------------------------------------------
module stk_step import stk_pkg::*; (
	input  var stk_state_t st,
	input  wire [7:0]      byte_req,
	input  wire            end_of_input,
	output stk_state_t     nst,
	output stk_res_t [1:0] res,
	output logic [1:0]     res_n
);

	function automatic stk_res_t mk(input logic [1:0] k, input logic [5:0] t,
			input logic [7:0] b, input logic [LINE_BITS-1:0] l,
			input logic [COLUMN_BITS-1:0] c, input logic [LENGTH_BITS-1:0] len,
			input logic [1:0] e);
		stk_res_t r;
		r.kind = k; r.token_type = t; r.literal_byte = b; r.line = l;
		r.column = c; r.literal_length = len; r.error_code = e; r.last = 1'b0;
		return r;
	endfunction

	function automatic void push(inout stk_res_t [1:0] rr, inout logic [1:0] n,
			input stk_res_t r);
		rr[n[0]] = r;
		n = n + 2'd1;
	endfunction

	function automatic void emit_lit(inout stk_state_t s, inout stk_res_t [1:0] rr,
			inout logic [1:0] n, input logic [7:0] c);
		if (s.cnt != LEN_TOP) s.cnt = s.cnt + 1'b1;
		push(rr, n, mk(KIND_LIT, 6'd0, c, s.st_line, s.st_col, s.cnt, ERR_NONE));
	endfunction

	function automatic void finish(inout stk_state_t s, inout stk_res_t [1:0] rr,
			inout logic [1:0] n, input logic [5:0] t);
		push(rr, n, mk(KIND_TOK, t, 8'd0, s.st_line, s.st_col, s.cnt, ERR_NONE));
		s.cnt = '0;
		s.mode = M_IDLE;
	endfunction

	function automatic void fail(inout stk_state_t s, inout stk_res_t [1:0] rr,
			inout logic [1:0] n, input logic [1:0] e, input logic [LINE_BITS-1:0] l,
			input logic [COLUMN_BITS-1:0] c);
		push(rr, n, mk(KIND_ERR, 6'd0, 8'd0, l, c, '0, e));
		s.mode = M_ERROR;
	endfunction

	function automatic logic [3:0] bool_adv(input logic [3:0] m, input logic [7:0] c);
		logic [3:0] r;
		r = 4'd15;
		case (m)
			4'd0: r = (c == "t") ? 4'd1 : ((c == "f") ? 4'd5 : 4'd15);
			4'd1: if (c == "r") r = 4'd2;
			4'd2: if (c == "u") r = 4'd3;
			4'd3: if (c == "e") r = 4'd4;
			4'd5: if (c == "a") r = 4'd6;
			4'd6: if (c == "l") r = 4'd7;
			4'd7: if (c == "s") r = 4'd8;
			4'd8: if (c == "e") r = 4'd9;
			default: r = 4'd15;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] unesc(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			"n": r = 8'd10;
			"r": r = 8'd13;
			"0": r = 8'd0;
			"a": r = 8'd7;
			"t": r = 8'd9;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [5:0] ident_type(input logic [3:0] m);
		return (m == 4'd4 || m == 4'd9) ? T_BOOL : T_ID;
	endfunction

	function automatic void fresh(inout stk_state_t s, inout stk_res_t [1:0] rr,
			inout logic [1:0] n, input logic [7:0] c);
		logic       one;
		logic [5:0] t;
		s.st_line = s.cur_line;
		s.st_col  = s.cur_col;
		s.cnt     = '0;
		s.mode    = M_IDLE;
		one = 1'b1;
		t   = T_ADD;
		case (c)
			"+": t = T_ADD;
			"-": t = T_SUB;
			"*": t = T_MUL;
			"/": t = T_DIV;
			"%": t = T_MOD;
			"~": t = T_TILDE;
			"^": t = T_XOR;
			"(": t = T_LPAR;
			")": t = T_RPAR;
			"[": t = T_LBRK;
			"]": t = T_RBRK;
			"{": t = T_LBRC;
			"}": t = T_RBRC;
			".": t = T_DOT;
			";": t = T_SEMI;
			",": t = T_COMMA;
			default: one = 1'b0;
		endcase
		if (one) begin
			push(rr, n, mk(KIND_TOK, t, 8'd0, s.cur_line, s.cur_col, '0, ERR_NONE));
		end else begin
			case (c)
				" ", 8'h09, 8'h0A, 8'h0D: s.mode = M_IDLE;
				"&": s.mode = M_AMP;
				"|": s.mode = M_BAR;
				"<": s.mode = M_LT;
				">": s.mode = M_GT;
				"!": s.mode = M_BANG;
				"=": s.mode = M_EQ;
				"#": s.mode = M_COMMENT;
				"\"": s.mode = M_STR;
				"'": begin
					s.mode = M_CHR;
					s.held = 8'd0;
					s.held_cnt = 2'd0;
				end
				default: begin
					if (is_digit(c)) begin
						s.mode = M_NUM;
						emit_lit(s, rr, n, c);
					end else if (is_alpha(c) || c == "_") begin
						s.mode = M_IDENT;
						s.bmatch = bool_adv(4'd0, c);
						emit_lit(s, rr, n, c);
					end else begin
						fail(s, rr, n, ERR_BADCHAR, s.cur_line, s.cur_col);
					end
				end
			endcase
		end
	endfunction

	function automatic void pair(inout stk_state_t s, inout stk_res_t [1:0] rr,
			inout logic [1:0] n, input logic [7:0] c, input logic [7:0] s1,
			input logic [5:0] t1, input logic has2, input logic [7:0] s2,
			input logic [5:0] t2, input logic [5:0] t0);
		if (c == s1) finish(s, rr, n, t1);
		else if (has2 && c == s2) finish(s, rr, n, t2);
		else begin
			finish(s, rr, n, t0);
			fresh(s, rr, n, c);
		end
	endfunction

	always_comb begin
		stk_state_t     s;
		stk_res_t [1:0] rr;
		logic [1:0]     n;
		logic           in_lit;
		logic [7:0]     c;
		s  = st;
		rr = '0;
		n  = 2'd0;
		c  = byte_req;
		in_lit = st.mode == M_STR || st.mode == M_STR_ESC ||
			st.mode == M_CHR || st.mode == M_CHR_ESC;
		if (st.mode != M_ERROR && st.mode != M_DONE) begin
			if (end_of_input || c == 8'd0) begin
				case (st.mode)
					M_AMP:   finish(s, rr, n, T_ANDL);
					M_BAR:   finish(s, rr, n, T_ORL);
					M_LT:    finish(s, rr, n, T_LT);
					M_GT:    finish(s, rr, n, T_GT);
					M_BANG:  finish(s, rr, n, T_NOTB);
					M_EQ:    finish(s, rr, n, T_ASSIGN);
					M_NUM:   finish(s, rr, n, T_INT);
					M_DEC:   finish(s, rr, n, T_DEC);
					M_IDENT: finish(s, rr, n, ident_type(st.bmatch));
					M_STR, M_STR_ESC, M_CHR, M_CHR_ESC:
						fail(s, rr, n, ERR_UNTERM, st.st_line, st.st_col);
					default: s.mode = st.mode;
				endcase
				if (s.mode != M_ERROR) s.mode = M_DONE;
			end else begin
				case (st.mode)
					M_AMP:  pair(s, rr, n, c, "&", T_ANDB, 1'b0, 8'd0, T_ADD, T_ANDL);
					M_BAR:  pair(s, rr, n, c, "|", T_ORB, 1'b0, 8'd0, T_ADD, T_ORL);
					M_LT:   pair(s, rr, n, c, "<", T_SHL, 1'b1, "=", T_LE, T_LT);
					M_GT:   pair(s, rr, n, c, ">", T_SHR, 1'b1, "=", T_GE, T_GT);
					M_BANG: pair(s, rr, n, c, "=", T_NE, 1'b0, 8'd0, T_ADD, T_NOTB);
					M_EQ:   pair(s, rr, n, c, "=", T_EQ, 1'b0, 8'd0, T_ADD, T_ASSIGN);
					M_NUM: begin
						if (is_digit(c)) emit_lit(s, rr, n, c);
						else if (c == ".") begin
							s.mode = M_DEC;
							emit_lit(s, rr, n, c);
						end else begin
							finish(s, rr, n, T_INT);
							fresh(s, rr, n, c);
						end
					end
					M_DEC: begin
						if (is_digit(c)) emit_lit(s, rr, n, c);
						else begin
							finish(s, rr, n, T_DEC);
							fresh(s, rr, n, c);
						end
					end
					M_IDENT: begin
						if (is_alpha(c) || is_digit(c) || c == "_") begin
							s.bmatch = bool_adv(st.bmatch, c);
							emit_lit(s, rr, n, c);
						end else begin
							finish(s, rr, n, ident_type(st.bmatch));
							fresh(s, rr, n, c);
						end
					end
					M_COMMENT: if (c == 8'h0A) s.mode = M_IDLE;
					M_STR: begin
						if (c == "\\") s.mode = M_STR_ESC;
						else if (c == "\"") finish(s, rr, n, T_STRING);
						else emit_lit(s, rr, n, c);
					end
					M_STR_ESC: begin
						emit_lit(s, rr, n, unesc(c));
						s.mode = M_STR;
					end
					M_CHR: begin
						if (c == "\\") s.mode = M_CHR_ESC;
						else if (c == "'") begin
							if (st.held_cnt == 2'd1) begin
								emit_lit(s, rr, n, st.held);
								finish(s, rr, n, T_CHAR);
							end else begin
								fail(s, rr, n, ERR_CHRSIZE, st.st_line, st.st_col);
							end
						end else begin
							if (st.held_cnt == 2'd0) s.held = c;
							if (st.held_cnt != 2'd2) s.held_cnt = st.held_cnt + 2'd1;
						end
					end
					M_CHR_ESC: begin
						if (st.held_cnt == 2'd0) s.held = unesc(c);
						if (st.held_cnt != 2'd2) s.held_cnt = st.held_cnt + 2'd1;
						s.mode = M_CHR;
					end
					default: fresh(s, rr, n, c);
				endcase
				// Positions advance after the byte is handled; a newline inside a
				// literal only moves the column.
				if (c == 8'h0A && !in_lit) begin
					if (s.cur_line != LINE_TOP) s.cur_line = s.cur_line + 1'b1;
					s.cur_col = {{(COLUMN_BITS-1){1'b0}}, 1'b1};
				end else if (s.cur_col != COL_TOP) begin
					s.cur_col = s.cur_col + 1'b1;
				end
			end
		end
		if (n == 2'd1) rr[0].last = 1'b1;
		if (n == 2'd2) rr[1].last = 1'b1;
		nst   = s;
		res   = rr;
		res_n = n;
	end

endmodule
`default_nettype wire

>>> hdl/stk_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stk_fifo
// Four-entry result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module stk_fifo import stk_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  var stk_res_t [1:0] wr_data,
	input  wire [1:0]      wr_n,
	output logic           room2,
	output logic           rd_valid,
	input  wire            rd_take,
	output stk_res_t       rd_data
);

	stk_res_t   mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;

	assign room2    = cnt_q <= 3'd2;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_n != 2'd0) mem_q[wp_q] <= wr_data[0];
		if (wr_n == 2'd2) mem_q[wp_q + 2'd1] <= wr_data[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + wr_n;
			rp_q  <= rp_q + {1'b0, rd_take};
			cnt_q <= cnt_q + {1'b0, wr_n} - {2'b0, rd_take};
		end
	end

endmodule
`default_nettype wire

>>> hdl/source_code_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_code_tokenizer
// Streams source bytes in and emits literal, token and error results.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries one source byte and an
// end-of-input flag per request. Each accepted request is decoded in the same
// cycle against the lexer state and its zero, one or two results are written
// into a four-entry result queue; the state register updates at that edge.
// The output channel (out_valid/out_stall) presents the queue head, so a
// result appears once it is registered and earlier results have left. One
// byte is taken per cycle while the queue has room for two results; the two
// results of one byte leave in turn, so sustained rate is one byte per cycle
// whenever results average one or fewer per byte. When the receiver stalls,
// the head holds and in_stall rises once fewer than two slots are free.
// Reset empties the queue and returns the lexer to line 1, column 1, between
// tokens. After an error or end of input no more results come until reset.
// ----------------------------------------------------------------------------
module source_code_tokenizer import stk_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire [7:0]             byte_req,
	input  wire                   end_of_input,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [1:0]            kind,
	output logic [5:0]            token_type,
	output logic [7:0]            literal_byte,
	output logic [LINE_BITS-1:0]  line,
	output logic [COLUMN_BITS-1:0] column,
	output logic [LENGTH_BITS-1:0] literal_length,
	output logic [1:0]            error_code,
	output logic                  last
);

	stk_state_t     st_q;
	stk_state_t     nst;
	stk_res_t [1:0] res;
	logic [1:0]     res_n;
	logic           room2;
	logic           acc;
	stk_res_t       head;

	stk_step u_step (
		.st(st_q), .byte_req(byte_req), .end_of_input(end_of_input),
		.nst(nst), .res(res), .res_n(res_n)
	);

	assign in_stall = !room2;
	assign acc      = in_valid && room2;

	stk_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_data(res), .wr_n(acc ? res_n : 2'd0),
		.room2(room2), .rd_valid(out_valid), .rd_take(out_valid && !out_stall),
		.rd_data(head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode     <= M_IDLE;
			st_q.cur_line <= {{(LINE_BITS-1){1'b0}}, 1'b1};
			st_q.cur_col  <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
			st_q.st_line  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
			st_q.st_col   <= {{(COLUMN_BITS-1){1'b0}}, 1'b1};
			st_q.cnt      <= '0;
			st_q.bmatch   <= 4'd0;
			st_q.held     <= 8'd0;
			st_q.held_cnt <= 2'd0;
		end else if (acc) begin
			st_q <= nst;
		end
	end

	assign kind           = head.kind;
	assign token_type     = head.token_type;
	assign literal_byte   = head.literal_byte;
	assign line           = head.line;
	assign column         = head.column;
	assign literal_length = head.literal_length;
	assign error_code     = head.error_code;
	assign last           = head.last;

`ifndef SYNTH
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ERR) |-> last)
		else $error("error request not marked last");
	a_lit_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_LIT) |-> (literal_length != '0))
		else $error("literal request with zero length");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_ERR) |-> (error_code == ERR_NONE))
		else $error("error code on a non-error request");
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == M_ERROR || st_q.mode == M_DONE) |=> (st_q.mode == $past(st_q.mode)))
		else $error("lexer left its final mode");
`endif

endmodule
`default_nettype wire
